>>> rtl/fehg_pkg.sv
// Shared constants and an address helper for the fire effect heat grid.
// Grid geometry, operation codes, and the constant-divide factors.
// No dependencies. Imported by fire_effect_heat_grid_unit.
`timescale 1ns / 1ps
`default_nettype none

package fehg_pkg;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 66;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W    = $clog2(CELLS);

  localparam int FUNC_W  = 2;
  localparam int ROW_W   = 7;
  localparam int COL_W   = 6;
  localparam int RND_W   = 15;
  localparam int HEAT_W  = 8;
  localparam int SUM_W   = 11;   // holds five times the largest cell value
  localparam int DECAY_W = 3;

  localparam logic [FUNC_W-1:0] OP_SEED   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_READ   = 2'd2;

  // sum / 5 as (sum * AVG_MUL) >> AVG_SH, exact for sums up to 1275.
  localparam int AVG_MUL = 6554;
  localparam int AVG_SH  = 15;
  localparam int AVG_PW  = SUM_W + 13;

  // rnd / 6 as (rnd * DEC_MUL) >> DEC_SH, exact for 15-bit values.
  localparam int DEC_MUL = 43691;
  localparam int DEC_SH  = 18;
  localparam int DEC_PW  = RND_W + 16;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(r) * ADDR_W'(GRID_COLS) + ADDR_W'(c);
    return a;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fire_effect_heat_grid_unit.sv
// Fire effect heat grid: top level with the grid memory and its sequencer.
// Depends on fehg_pkg for geometry, operation codes and address helper.
//
// Usage: items enter on the in_ channel (valid/stall) and each one gives
// exactly one result on the out_ channel. A transfer takes place on a rising
// edge where valid is high and stall is low.
//   seed   - writes random_value[7:0] into one cell and returns it.
//   update - averages a cell with its four neighbors, subtracts
//            random_value mod 6 (floor 0), writes the cell one row up.
//   read   - returns one cell.
// Bad addresses and the unused code return status 1, value 0, no change.
// Seed and rejected items go straight to the final step S_FIN; a read passes
// S_RD first, and an update passes S_UP1, S_UP2, S_UP3 and S_CALC. One item
// is in work at a time, so an item occupies the block until it is done; the
// update steps come from five cell reads through the two read ports of the grid memory.
// The output register lets the next item be taken while a result waits; a
// stalled result holds the block in its final step until it is taken.
// After reset the grid is cleared one cell a cycle, all 4224 cells, during
// which in_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module fire_effect_heat_grid_unit
  import fehg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [FUNC_W-1:0]   in_func,
  input  wire logic [ROW_W-1:0]    in_row,
  input  wire logic [COL_W-1:0]    in_col,
  input  wire logic [RND_W-1:0]    in_random_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [HEAT_W-1:0]        out_cell_value,
  output logic                     out_status
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_UP1, S_UP2, S_UP3, S_CALC, S_FIN
  } state_t;

  state_t state_r;

  logic [HEAT_W-1:0]  mem [0:CELLS-1];
  logic [HEAT_W-1:0]  rda_r, rdb_r;

  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [FUNC_W-1:0]  func_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [RND_W-1:0]   rnd_r;
  logic               ok_r;
  logic               below_ok_r;
  logic [SUM_W-1:0]   sum_r;
  logic [HEAT_W-1:0]  avg_r;
  logic [DECAY_W-1:0] decay_r;
  logic [HEAT_W-1:0]  value_r;
  logic               out_valid_r;
  logic [HEAT_W-1:0]  out_value_r;
  logic               out_status_r;

  logic               accept;
  logic               in_grid, upd_ok, op_ok;
  logic               fin_fire;
  logic [HEAT_W-1:0]  fin_value;
  logic               we;
  logic [ADDR_W-1:0]  wa, ra_a, ra_b;
  logic [HEAT_W-1:0]  wd;
  logic [AVG_PW-1:0]  avg_prod;
  logic [DEC_PW-1:0]  dec_prod;
  logic [RND_W-1:0]   dec_q, dec_rem;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign in_grid = (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);
  assign upd_ok  = in_grid && (in_row != '0) && (in_col != '0) &&
                   (32'(in_col) + 1 < GRID_COLS);

  always_comb begin
    case (in_func)
      OP_SEED:   op_ok = in_grid;
      OP_READ:   op_ok = in_grid;
      OP_UPDATE: op_ok = upd_ok;
      default:   op_ok = 1'b0;
    endcase
  end

  // Constant divides by reciprocal multiplication.
  assign avg_prod = AVG_PW'(sum_r) * AVG_PW'(AVG_MUL);
  assign dec_prod = DEC_PW'(rnd_r) * DEC_PW'(DEC_MUL);
  assign dec_q    = RND_W'(dec_prod >> DEC_SH);
  assign dec_rem  = rnd_r - ((dec_q << 2) + (dec_q << 1));

  assign fin_value = (func_r == OP_UPDATE && ok_r) ?
                     ((avg_r > HEAT_W'(decay_r)) ? avg_r - HEAT_W'(decay_r) : '0) :
                     value_r;
  assign fin_fire  = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // Memory port selection.
  always_comb begin
    we   = 1'b0;
    wa   = cell_addr(in_row, in_col);
    wd   = in_random_value[HEAT_W-1:0];
    ra_a = cell_addr(in_row, in_col);
    ra_b = cell_addr(in_row - 1'b1, in_col);
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt_r;
        wd = '0;
      end
      S_IDLE: begin
        we = accept && op_ok && (in_func == OP_SEED);
      end
      S_UP1: begin
        ra_a = cell_addr(row_r, col_r - 1'b1);
        ra_b = cell_addr(row_r, col_r + 1'b1);
      end
      S_UP2: begin
        ra_a = cell_addr(row_r + 1'b1, col_r);
      end
      S_FIN: begin
        we = fin_fire && ok_r && (func_r == OP_UPDATE);
        wa = cell_addr(row_r - 1'b1, col_r);
        wd = fin_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_r <= mem[ra_a];
    rdb_r <= mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result in the same cycle keeps the flag set below.
      if (out_valid_r && !out_stall && !fin_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_r  <= in_func;
            row_r   <= in_row;
            col_r   <= in_col;
            rnd_r   <= in_random_value;
            ok_r    <= op_ok;
            value_r <= (op_ok && in_func == OP_SEED) ?
                       in_random_value[HEAT_W-1:0] : '0;
            if (op_ok && in_func == OP_READ) begin
              state_r <= S_RD;
            end else if (op_ok && in_func == OP_UPDATE) begin
              state_r <= S_UP1;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_RD: begin
          value_r <= rda_r;
          state_r <= S_FIN;
        end
        S_UP1: begin
          // Center and the cell above arrive now.
          sum_r      <= SUM_W'(rda_r) + SUM_W'(rdb_r);
          decay_r    <= dec_rem[DECAY_W-1:0];
          below_ok_r <= (32'(row_r) + 1 < GRID_ROWS);
          state_r    <= S_UP2;
        end
        S_UP2: begin
          sum_r   <= sum_r + SUM_W'(rda_r) + SUM_W'(rdb_r);
          state_r <= S_UP3;
        end
        S_UP3: begin
          // The cell below the bottom row counts as zero.
          sum_r   <= sum_r + (below_ok_r ? SUM_W'(rda_r) : '0);
          state_r <= S_CALC;
        end
        S_CALC: begin
          avg_r   <= HEAT_W'(avg_prod >> AVG_SH);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_fire) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= fin_value;
            out_status_r <= !ok_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_status     = out_status_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("input taken during the clearing pass");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN))
    else $error("result appeared outside the final step");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in work");

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC) |-> (sum_r <= SUM_W'(5 * 255)))
    else $error("neighbor sum out of range");

  a_decay_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && func_r == OP_UPDATE && ok_r) |-> (decay_r < DECAY_W'(6)))
    else $error("decay not reduced modulo six");

endmodule

`default_nettype wire
